FILE: sv/rpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_pkg: shared constants and helpers for the particle push step
// Codes, fixed-point constants and magnitude helpers used by the push step module.
// ----------------------------------------------------------------------------
package rpp_pkg;

    localparam int POS_WIDTH_DEF = 48;

    // configuration register indexes
    localparam logic [2:0] CFG_B_COEFF  = 3'd0;
    localparam logic [2:0] CFG_E_COEFF  = 3'd1;
    localparam logic [2:0] CFG_MAG_END  = 3'd2;
    localparam logic [2:0] CFG_SCR_END  = 3'd3;
    localparam logic [2:0] CFG_WALL     = 3'd4;
    localparam logic [2:0] CFG_STEP_LEN = 3'd5;

    // result status codes
    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_FLIGHT  = 2'd1;
    localparam logic [1:0] ST_WALL    = 2'd2;
    localparam logic [1:0] ST_NO_STEP = 2'd3;

    localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
    localparam logic [63:0] CLAMP_OM  = 64'd1152921504607;
    localparam logic [33:0] GAMMA_MAX = 34'h3_FFFF_FFFF;

    // reset values of the configuration registers
    localparam logic [46:0] MAG_END_RST = 47'd219902325555;
    localparam logic [46:0] SCR_END_RST = 47'd1319413953331;
    localparam logic [46:0] WALL_RST    = 47'd1319413953331;
    localparam logic [31:0] STEP_RST    = 32'd32962260;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        mag64 = a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        mag32 = a[31] ? (32'd0 - a) : a;
    endfunction

endpackage
`default_nettype wire

FILE: sv/rpp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_if: channel interfaces of the particle push step
// Request input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
interface rpp_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [29:0]        start_beta_x;
    logic signed [47:0] start_y;
    logic signed [47:0] start_z;
    logic               charge_negative;

    modport source (output valid, func, start_beta_x, start_y, start_z, charge_negative,
                    input ready);
    modport sink   (input valid, func, start_beta_x, start_y, start_z, charge_negative,
                    output ready);
endinterface

interface rpp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic [33:0]        lorentz_gamma;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic               charge_sign;

    modport source (output valid, status, pos_x, pos_y, pos_z, lorentz_gamma,
                    speed_x, speed_y, charge_sign, input ready);
    modport sink   (input valid, status, pos_x, pos_y, pos_z, lorentz_gamma,
                    speed_x, speed_y, charge_sign, output ready);
endinterface

interface rpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/relativistic_particle_push_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// relativistic_particle_push_step: one semi-implicit Euler push of a particle
// Load a particle, then advance it one time step per request through a
// crossed E/B field region, reporting position, gamma and status.
// ----------------------------------------------------------------------------
// A load request goes straight to the result. A step request on a live particle
// runs two squaring passes of the shared 32x32 multiplier, a 32-step bit-pair
// square root for 1/gamma and a 35-step restoring division for gamma, then
// up to four field products and two position products; each multiply passes
// through the low, high, rounding and next states, and all multiplies share
// one unit. A step outside the magnet skips the field products. A step on
// an ended particle or past the screen gets ST_NO_STEP. The block takes one
// request at a time; a finished result waits in the output register while the
// next request is accepted. Register writes are always taken.
module relativistic_particle_push_step #(
    parameter int POSITION_WIDTH = rpp_pkg::POS_WIDTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rpp_in_if.sink     i_in,
    rpp_out_if.source  o_out,
    rpp_cfg_if.sink    i_cfg
);
    import rpp_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int EW = 66;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MLO  = 4'd1;
    localparam logic [3:0] S_MHI  = 4'd2;
    localparam logic [3:0] S_MRND = 4'd3;
    localparam logic [3:0] S_NEXT = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;

    localparam logic [2:0] OP_SQX = 3'd0;
    localparam logic [2:0] OP_SQY = 3'd1;
    localparam logic [2:0] OP_FB  = 3'd2;
    localparam logic [2:0] OP_DVX = 3'd3;
    localparam logic [2:0] OP_FE  = 3'd4;
    localparam logic [2:0] OP_DVY = 3'd5;
    localparam logic [2:0] OP_DX  = 3'd6;
    localparam logic [2:0] OP_DY  = 3'd7;

    localparam logic signed [EW-1:0] PMAX = (EW'(1) <<< (PW - 1)) - EW'(1);
    localparam logic signed [EW-1:0] PMIN = -PMAX - EW'(1);

    // below this 1/gamma the quotient no longer fits 34 bits
    localparam logic [30:0] INV_SAT = 31'd1048576;

    // sequencer
    logic [3:0] r_state;
    logic [2:0] r_op;
    logic [5:0] r_cnt;

    // particle
    logic signed [PW-1:0] r_x, r_y, r_z;
    logic signed [31:0]   r_bx, r_by;
    logic                 r_neg, r_ended;

    // configuration
    logic signed [47:0] r_cb, r_ce;
    logic [46:0]        r_mend, r_send, r_wall;
    logic [31:0]        r_step;

    // shared multiplier operands and accumulator
    logic [63:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_mneg, r_sh40;
    logic [95:0]        r_acc;
    logic signed [63:0] r_mres;

    // square root, division and intermediates
    logic [63:0]        r_b2, r_n, r_res, r_bit;
    logic [30:0]        r_inv;
    logic [32:0]        r_rem;
    logic [34:0]        r_q;
    logic signed [63:0] r_dvx;
    logic [1:0]         r_status;
    logic [33:0]        r_gamma;

    // output register
    logic               r_ovalid;
    logic [1:0]         r_o_status;
    logic [47:0]        r_o_x, r_o_y, r_o_z;
    logic [33:0]        r_o_gamma;
    logic [31:0]        r_o_bx, r_o_by;
    logic               r_o_neg;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic signed [EW-1:0] ext_pos(input logic signed [PW-1:0] v);
        ext_pos = EW'(v);
    endfunction

    function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] a,
                                                     input logic signed [63:0] d);
        logic signed [PW:0] s;
        s = {a[PW-1], a} + {d[PW-1], d[PW-1:0]};
        if (s[PW] != s[PW-1]) begin
            sat_add = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            sat_add = s[PW-1:0];
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            clamp32 = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            clamp32 = 32'sh8000_0000;
        end else begin
            clamp32 = v[31:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // shared arithmetic
    // ------------------------------------------------------------------
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [95:0] acc_r, acc_c;
    logic signed [63:0] mres_v;

    assign mul_a = (r_state == S_MHI) ? r_ma[63:32] : r_ma[31:0];
    assign mul_p = mul_a * r_mb;

    always_comb begin
        // round magnitude half up, then cap and apply sign
        acc_r = r_sh40 ? ((r_acc + (96'd1 << 39)) >> 40) : ((r_acc + (96'd1 << 29)) >> 30);
        acc_c = (acc_r > (96'd1 << 62)) ? (96'd1 << 62) : acc_r;
        mres_v = r_mneg ? (64'sd0 - $signed(acc_c[63:0])) : $signed(acc_c[63:0]);
    end

    // square root step
    logic [63:0] sq_t, n_n, n_res;
    always_comb begin
        sq_t = r_res + r_bit;
        if (r_n >= sq_t) begin
            n_n   = r_n - sq_t;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_n   = r_n;
            n_res = r_res >> 1;
        end
    end

    // division step
    logic [32:0] dv_r2, n_rem;
    logic        dv_ge;
    logic [34:0] n_q;
    always_comb begin
        dv_r2 = {r_rem[31:0], 1'b0};
        dv_ge = dv_r2 >= {2'b00, r_inv};
        n_rem = dv_ge ? (dv_r2 - {2'b00, r_inv}) : dv_r2;
        n_q   = {r_q[33:0], dv_ge};
    end

    // b2 and 1 - b2 with clamp
    logic [64:0] b2_sum;
    logic [63:0] om_v;
    always_comb begin
        b2_sum = {1'b0, r_b2} + {1'b0, r_acc[63:0]};
        om_v   = (b2_sum >= {1'b0, ONE_Q60}) ? CLAMP_OM : (ONE_Q60 - b2_sum[63:0]);
    end

    // field difference and new velocities
    logic signed [63:0] fe_diff, dvx_s, dvy_s;
    logic signed [31:0] c_nbx, c_nby;
    always_comb begin
        fe_diff = 64'(r_ce) - r_mres;
        dvx_s   = r_neg ? (64'sd0 - r_dvx) : r_dvx;
        dvy_s   = r_neg ? (64'sd0 - r_mres) : r_mres;
        c_nbx   = clamp32(64'(r_bx) + dvx_s);
        c_nby   = clamp32(64'(r_by) + dvy_s);
    end

    // position checks
    logic signed [EW-1:0] x_e, y_e, z_e, ny_e, sy_e, sz_e;
    logic signed [PW-1:0] c_ny, c_sy, c_sz;
    logic [EW-1:0]        ny_mag;
    logic                 past_screen, in_magnet, hit_wall;
    always_comb begin
        x_e         = ext_pos(r_x);
        y_e         = ext_pos(r_y);
        z_e         = ext_pos(r_z);
        past_screen = x_e >= $signed({19'd0, r_send});
        in_magnet   = x_e <= $signed({19'd0, r_mend});
        c_ny        = sat_add(r_y, r_mres);
        ny_e        = ext_pos(c_ny);
        ny_mag      = ny_e[EW-1] ? (EW'(0) - ny_e) : ny_e;
        hit_wall    = ny_mag > {19'd0, r_wall};
        sy_e        = EW'(i_in.start_y);
        sz_e        = EW'(i_in.start_z);
        c_sy = (sy_e > PMAX) ? PMAX[PW-1:0] : ((sy_e < PMIN) ? PMIN[PW-1:0] : sy_e[PW-1:0]);
        c_sz = (sz_e > PMAX) ? PMAX[PW-1:0] : ((sz_e < PMIN) ? PMIN[PW-1:0] : sz_e[PW-1:0]);
    end

    logic in_fire, emit_fire;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign emit_fire  = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_SQX;
            r_cnt    <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
            r_bx     <= '0;
            r_by     <= '0;
            r_neg    <= 1'b0;
            r_ended  <= 1'b1;
            r_cb     <= '0;
            r_ce     <= '0;
            r_mend   <= MAG_END_RST;
            r_send   <= SCR_END_RST;
            r_wall   <= WALL_RST;
            r_step   <= STEP_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_B_COEFF:  r_cb   <= i_cfg.data;
                    CFG_E_COEFF:  r_ce   <= i_cfg.data;
                    CFG_MAG_END:  r_mend <= i_cfg.data[46:0];
                    CFG_SCR_END:  r_send <= i_cfg.data[46:0];
                    CFG_WALL:     r_wall <= i_cfg.data[46:0];
                    CFG_STEP_LEN: r_step <= i_cfg.data[31:0];
                    default: ;
                endcase
            end

            // post a new result, or drop the one taken by the sink
            if (emit_fire) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_gamma <= '0;
                        if (!i_in.func) begin
                            // load a new particle at x = 0
                            r_x      <= '0;
                            r_y      <= c_sy;
                            r_z      <= c_sz;
                            r_bx     <= {2'b00, i_in.start_beta_x};
                            r_by     <= '0;
                            r_neg    <= i_in.charge_negative;
                            r_ended  <= 1'b0;
                            r_status <= ST_LOADED;
                            r_state  <= S_EMIT;
                        end else if (r_ended || past_screen) begin
                            r_status <= ST_NO_STEP;
                            r_state  <= S_EMIT;
                        end else begin
                            r_op    <= OP_SQX;
                            r_ma    <= {32'd0, mag32(r_bx)};
                            r_mb    <= mag32(r_bx);
                            r_mneg  <= 1'b0;
                            r_sh40  <= 1'b0;
                            r_state <= S_MLO;
                        end
                    end
                end
                S_MLO: begin
                    r_acc   <= {32'd0, mul_p};
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_acc   <= r_acc + {mul_p, 32'd0};
                    r_state <= S_MRND;
                end
                S_MRND: begin
                    r_mres  <= mres_v;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    case (r_op)
                        OP_SQX: begin
                            r_b2    <= r_acc[63:0];
                            r_op    <= OP_SQY;
                            r_ma    <= {32'd0, mag32(r_by)};
                            r_mb    <= mag32(r_by);
                            r_state <= S_MLO;
                        end
                        OP_SQY: begin
                            r_n     <= om_v;
                            r_res   <= '0;
                            r_bit   <= 64'd1 << 62;
                            r_cnt   <= '0;
                            r_state <= S_SQRT;
                        end
                        OP_FB: begin
                            r_op    <= OP_DVX;
                            r_ma    <= mag64(r_mres);
                            r_mb    <= {1'b0, r_inv};
                            r_mneg  <= r_mres[63];
                            r_sh40  <= 1'b1;
                            r_state <= S_MLO;
                        end
                        OP_DVX: begin
                            r_dvx   <= r_mres;
                            r_op    <= OP_FE;
                            r_ma    <= mag64(64'(r_cb));
                            r_mb    <= mag32(r_bx);
                            r_mneg  <= r_cb[47] ^ r_bx[31];
                            r_sh40  <= 1'b0;
                            r_state <= S_MLO;
                        end
                        OP_FE: begin
                            r_op    <= OP_DVY;
                            r_ma    <= mag64(fe_diff);
                            r_mb    <= {1'b0, r_inv};
                            r_mneg  <= fe_diff[63];
                            r_sh40  <= 1'b1;
                            r_state <= S_MLO;
                        end
                        OP_DVY: begin
                            r_bx    <= c_nbx;
                            r_by    <= c_nby;
                            r_op    <= OP_DX;
                            r_ma    <= {32'd0, mag32(c_nbx)};
                            r_mb    <= r_step;
                            r_mneg  <= c_nbx[31];
                            r_sh40  <= 1'b0;
                            r_state <= S_MLO;
                        end
                        OP_DX: begin
                            r_x     <= sat_add(r_x, r_mres);
                            r_op    <= OP_DY;
                            r_ma    <= {32'd0, mag32(r_by)};
                            r_mb    <= r_step;
                            r_mneg  <= r_by[31];
                            r_sh40  <= 1'b0;
                            r_state <= S_MLO;
                        end
                        OP_DY: begin
                            r_y      <= c_ny;
                            r_status <= hit_wall ? ST_WALL : ST_FLIGHT;
                            if (hit_wall) begin
                                r_ended <= 1'b1;
                            end
                            r_state  <= S_EMIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SQRT: begin
                    // one bit pair of the root per cycle
                    r_n   <= n_n;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 6'd31) begin
                        r_inv   <= n_res[30:0];
                        r_rem   <= 33'd524288;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    // one quotient bit of 2^54 / inv per cycle
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd34) begin
                        r_gamma <= (n_q[34] || (r_inv < INV_SAT)) ? GAMMA_MAX : n_q[33:0];
                        r_sh40  <= 1'b0;
                        r_state <= S_MLO;
                        if (in_magnet) begin
                            r_op   <= OP_FB;
                            r_ma   <= mag64(64'(r_cb));
                            r_mb   <= mag32(r_by);
                            r_mneg <= r_cb[47] ^ r_by[31];
                        end else begin
                            // outside the field region: keep velocity, go move
                            r_op   <= OP_DX;
                            r_ma   <= {32'd0, mag32(r_bx)};
                            r_mb   <= r_step;
                            r_mneg <= r_bx[31];
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output payload, captured when the result is posted
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_o_status <= r_status;
            r_o_x      <= x_e[47:0];
            r_o_y      <= y_e[47:0];
            r_o_z      <= z_e[47:0];
            r_o_gamma  <= r_gamma;
            r_o_bx     <= r_bx;
            r_o_by     <= r_by;
            r_o_neg    <= r_neg;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_o_status;
    assign o_out.pos_x         = r_o_x;
    assign o_out.pos_y         = r_o_y;
    assign o_out.pos_z         = r_o_z;
    assign o_out.lorentz_gamma = r_o_gamma;
    assign o_out.speed_x       = r_o_bx;
    assign o_out.speed_y       = r_o_by;
    assign o_out.charge_sign   = r_o_neg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_load_clears_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_in.func |=> !r_ended && (r_status == ST_LOADED))
        else $error("load did not arm the particle");

    a_gamma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && (r_status == ST_LOADED || r_status == ST_NO_STEP) |-> r_gamma == '0)
        else $error("gamma reported on a load or skipped step");

    a_flight_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && (r_status == ST_FLIGHT) |-> !r_ended)
        else $error("in-flight status on an ended particle");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_inv != '0)
        else $error("reciprocal gamma is zero");

endmodule
`default_nettype wire
